>>> rtl/core/rrts_pkg.sv
package rrts_pkg;

    // Task count; ring indexing wraps by truncation, so keep it a power of two.
    localparam int TASKS  = 16;
    localparam int TASK_W = $clog2(TASKS);
    localparam int CNT_W  = $clog2(TASKS + 1);

    localparam logic [3:0] QUANTUM_RESET = 4'd3;

    localparam logic [1:0] OP_CONTINUE = 2'd0;
    localparam logic [1:0] OP_IO       = 2'd1;
    localparam logic [1:0] OP_FINISH   = 2'd2;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_SLEEP   = 2'd2,
        ST_DONE    = 2'd3
    } task_state_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] sleep_ticks;
    } in_item_t;

    typedef struct packed {
        logic       worked_valid;
        logic [3:0] worked_task;
        logic       running_valid;
        logic [3:0] running_task;
        logic [3:0] quantum_left;
        logic [4:0] woke_count;
        logic [4:0] finished_count;
        logic       all_finished;
    } out_item_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [TASK_W-1:0] push_task;
    } ring_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [TASK_W-1:0] head_task;
    } ring_stat_t;

endpackage

>>> rtl/core/rrts_ring.sv
module rrts_ring (
    input  logic                aclk,
    input  logic                aresetn,
    input  rrts_pkg::ring_ctl_t ctl,
    output rrts_pkg::ring_stat_t stat
);
    import rrts_pkg::*;

    logic [TASK_W-1:0] slot_reg [TASKS];
    logic [TASK_W-1:0] head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TASK_W-1:0] tail;
    logic              do_push;
    logic              do_pop;

    assign tail    = head_reg + count_reg[TASK_W-1:0];
    assign do_push = ctl.push && (count_reg < CNT_W'(TASKS));
    assign do_pop  = ctl.pop && (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASKS; i++) begin
                slot_reg[i] <= TASK_W'((i + 1) % TASKS);
            end
            head_reg  <= '0;
            count_reg <= CNT_W'(TASKS - 1);
        end else begin
            if (do_push) begin
                slot_reg[tail] <= ctl.push_task;
            end
            if (do_pop) begin
                head_reg <= head_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign stat.count     = count_reg;
    assign stat.head_task = slot_reg[head_reg];

`ifndef SYNTHESIS
    // only ready tasks are queued, so the ring never overflows
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.push |-> (count_reg < CNT_W'(TASKS)))
        else $error("ring push while full");
    a_no_mixed: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.push && ctl.pop))
        else $error("ring push and pop in one cycle");
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("ring count not decremented on pop");
`endif

endmodule

>>> rtl/core/round_robin_tick_scheduler_top.sv
// Round-robin tick scheduler. One input transfer is one timer tick and carries
// the outcome of the running task (continue, I/O sleep with a length, finish);
// each tick yields exactly one result transfer. A tick that dispatches a task
// goes through the sleep-counter walk, one task (of 16) at a time through
// the single status/counter read port, then charge, requeue, dispatch and
// output-load steps. A tick where the running task just keeps going skips
// requeue and dispatch. The next tick can transfer on the cycle after the
// result loads. s_ready is high only while the sequencer is idle; the
// result sits in an output register, so a new tick is taken while it waits,
// and that tick holds in its output-load step until the register frees.
// The quantum register (reset 3) is written with cfg_we/cfg_wdata and should
// only change while no tick is in flight. After reset task 0 runs and tasks
// 1..15 sit in the ready ring in order.
module round_robin_tick_scheduler_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  rrts_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rrts_pkg::out_item_t m_data
);
    import rrts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CHARGE,
        S_REQUEUE,
        S_POP,
        S_FINISH
    } seq_state_t;

    seq_state_t        state_reg;
    logic [3:0]        quantum_reg;

    // per-task state, accessed at one address per cycle
    task_state_t       status_reg [TASKS];
    logic [3:0]        sleep_reg  [TASKS];

    logic [TASK_W-1:0] idx_reg;
    in_item_t          item_reg;
    logic [4:0]        woke_reg;
    logic              worked_reg;
    logic [TASK_W-1:0] worked_task_reg;
    logic [TASK_W-1:0] cur_reg;
    logic              cur_valid_reg;
    logic [3:0]        qcount_reg;
    logic [4:0]        fin_reg;

    logic              m_valid_reg;
    out_item_t         m_data_reg;

    ring_ctl_t         ring_ctl;
    ring_stat_t        ring_stat;

    logic [TASK_W-1:0] st_addr;
    task_state_t       st_rd;
    logic [3:0]        sleep_dec;
    logic [3:0]        qcount_dec;
    logic              s_xfer;
    logic              out_free;
    out_item_t         result;

    // shared read port: walk index, otherwise the running task
    assign st_addr    = (state_reg == S_WALK) ? idx_reg : cur_reg;
    assign st_rd      = status_reg[st_addr];
    assign sleep_dec  = sleep_reg[idx_reg] - 4'd1;
    assign qcount_dec = qcount_reg - 4'd1;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        ring_ctl = '0;
        unique case (state_reg)
            S_WALK: begin
                ring_ctl.push      = (st_rd == ST_SLEEP) && (sleep_dec == 4'd0);
                ring_ctl.push_task = idx_reg;
            end
            S_REQUEUE: begin
                ring_ctl.push      = cur_valid_reg && (st_rd == ST_RUNNING);
                ring_ctl.push_task = cur_reg;
            end
            S_POP: begin
                ring_ctl.pop = (ring_stat.count != '0);
            end
            default: ring_ctl = '0;
        endcase
    end

    rrts_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ring_ctl),
        .stat    (ring_stat)
    );

    always_comb begin
        result.worked_valid   = worked_reg;
        result.worked_task    = worked_reg ? 4'(worked_task_reg) : 4'd0;
        result.running_valid  = cur_valid_reg;
        result.running_task   = cur_valid_reg ? 4'(cur_reg) : 4'd0;
        result.quantum_left   = cur_valid_reg ? qcount_reg : 4'd0;
        result.woke_count     = woke_reg;
        result.finished_count = fin_reg;
        result.all_finished   = (fin_reg == 5'(TASKS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= QUANTUM_RESET;
        end else if (cfg_we) begin
            quantum_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < TASKS; i++) begin
                status_reg[i] <= (i == 0) ? ST_RUNNING : ST_READY;
            end
            idx_reg       <= '0;
            woke_reg      <= '0;
            worked_reg    <= 1'b0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b1;
            qcount_reg    <= QUANTUM_RESET;
            fin_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // the output-load step sets valid itself when the register frees
            if (m_valid_reg && m_ready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_xfer) begin
                        item_reg   <= s_data;
                        idx_reg    <= '0;
                        woke_reg   <= '0;
                        worked_reg <= 1'b0;
                        state_reg  <= S_WALK;
                    end
                end
                S_WALK: begin
                    // count down one sleeper; wake it on zero
                    if (st_rd == ST_SLEEP) begin
                        sleep_reg[idx_reg] <= sleep_dec;
                        if (sleep_dec == 4'd0) begin
                            status_reg[idx_reg] <= ST_READY;
                            woke_reg            <= woke_reg + 5'd1;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == TASK_W'(TASKS - 1)) begin
                        state_reg <= S_CHARGE;
                    end
                end
                S_CHARGE: begin
                    if (cur_valid_reg) begin
                        worked_reg      <= 1'b1;
                        worked_task_reg <= cur_reg;
                        qcount_reg      <= qcount_dec;
                        priority if (item_reg.opcode == OP_IO) begin
                            status_reg[cur_reg] <= ST_SLEEP;
                            sleep_reg[cur_reg]  <= item_reg.sleep_ticks;
                            state_reg           <= S_REQUEUE;
                        end else if (item_reg.opcode == OP_FINISH) begin
                            status_reg[cur_reg] <= ST_DONE;
                            fin_reg             <= fin_reg + 5'd1;
                            state_reg           <= S_REQUEUE;
                        end else if (qcount_dec == 4'd0) begin
                            state_reg <= S_REQUEUE;
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end else if (ring_stat.count != '0) begin
                        state_reg <= S_REQUEUE;
                    end else begin
                        state_reg <= S_FINISH;
                    end
                end
                S_REQUEUE: begin
                    // quantum expiry: running task goes to the ring tail
                    if (ring_ctl.push) begin
                        status_reg[cur_reg] <= ST_READY;
                    end
                    state_reg <= S_POP;
                end
                S_POP: begin
                    if (ring_ctl.pop) begin
                        cur_reg                       <= ring_stat.head_task;
                        cur_valid_reg                 <= 1'b1;
                        status_reg[ring_stat.head_task] <= ST_RUNNING;
                        qcount_reg                    <= quantum_reg;
                    end else begin
                        cur_reg       <= '0;
                        cur_valid_reg <= 1'b0;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_data_reg  <= result;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_ready)
        else $error("tick accepted but sequencer still idle");
    a_fin_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg <= 5'(TASKS))
        else $error("finished count beyond task count");
    a_idle_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.running_valid) |->
            (m_data_reg.running_task == 4'd0 && m_data_reg.quantum_left == 4'd0))
        else $error("idle result carries a running task");
    a_all_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.all_finished) |-> !m_data_reg.running_valid)
        else $error("task running after all finished");
`endif

endmodule
